@@ design/hcb_pkg.sv @@
`timescale 1ns / 1ps
package hcb_pkg;
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_BUILD = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIND,
        ST_MERGE,
        ST_DONE
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic load;
        logic clear;
        logic merge;
    } cell_cmd_t;
endpackage

@@ design/hcb_if.sv @@
`timescale 1ns / 1ps
interface hcb_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/hcb_cell.sv @@
`timescale 1ns / 1ps
// One cell per symbol. Its group is the slot of the symbol that heads it; weights are
// compared over the chain by the controller, and every cell applies the merge itself.
module hcb_cell #(
    parameter int IDX_BITS  = 8,
    parameter int W_BITS    = 32,
    parameter int C_BITS    = 24,
    parameter int CODE_BITS = 48,
    parameter int LEN_BITS  = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcb_pkg::cell_cmd_t   cmd,
    input  logic [IDX_BITS-1:0]  my_idx,
    input  logic [C_BITS-1:0]    count,
    input  logic [IDX_BITS-1:0]  slot_a,
    input  logic [IDX_BITS-1:0]  slot_b,
    input  logic [W_BITS-1:0]    weight_a,
    output logic [W_BITS-1:0]    weight,
    output logic [CODE_BITS-1:0] code_bits,
    output logic [LEN_BITS-1:0]  code_length,
    output logic                 ovf
);
    import hcb_pkg::*;
    logic [W_BITS-1:0]    w_reg;
    logic [IDX_BITS-1:0]  g_reg;
    logic [CODE_BITS-1:0] c_reg;
    logic [LEN_BITS-1:0]  l_reg;
    logic                 in_a, in_b, full;

    assign in_a = (count != '0) && (g_reg == slot_a);
    assign in_b = (count != '0) && (g_reg == slot_b);
    assign full = (l_reg == LEN_BITS'(CODE_BITS));
    assign ovf  = cmd.merge && (in_a || in_b) && full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
            c_reg <= '0;
            l_reg <= '0;
            g_reg <= '0;
        end
        else if (cmd.clear)
        begin
            w_reg <= '0;
            c_reg <= '0;
            l_reg <= '0;
        end
        else if (cmd.load)
        begin
            w_reg <= W_BITS'(count);
            g_reg <= my_idx;
        end
        else if (cmd.merge)
        begin
            if (my_idx == slot_b)
                w_reg <= w_reg + weight_a;
            else if (my_idx == slot_a)
                w_reg <= '0;
            if ((in_a || in_b) && !full)
            begin
                c_reg <= c_reg | (CODE_BITS'(in_b) << l_reg);
                l_reg <= l_reg + 1'b1;
            end
            if (in_a)
                g_reg <= slot_b;
        end
    end

    assign weight      = w_reg;
    assign code_bits   = c_reg;
    assign code_length = l_reg;
endmodule

@@ design/huffman_code_builder.sv @@
`timescale 1ns / 1ps
// Huffman code builder for byte symbols.
// The in channel carries requests {opcode, symbol, count}; the out channel carries
// results {code_length, code_bits, active_symbols, length_overflow}.
// A write stores one count and is taken with no result.
// A read gives its result in the cycle after acceptance. The input stays blocked until
// that result is taken, so no new request is accepted while a read result waits.
// A build gives one result with the active symbol count and overflow flag. Groups
// start at the slot of their lowest symbol; each merge takes one scan over the row
// of cells to find the two lightest groups and then merges them, and the build
// ends with its result once a scan finds fewer than two groups, as with no symbols.
// Ready is low throughout a build and while a result waits.
// Reset clears all counts and codes; no clearing pass is needed.
// When the receiver stalls the result holds in the output register and no new
// request is accepted until it is taken.
module huffman_code_builder #(
    parameter int NUM_SYMBOLS   = 256,
    parameter int COUNT_BITS    = 24,
    parameter int MAX_CODE_BITS = 48
) (
    input logic clk,
    input logic rst_n,
    hcb_if.sink   in_ch,
    hcb_if.source out_ch
);
    import hcb_pkg::*;
    localparam int IB = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CB = IB + 1;
    localparam int WB = COUNT_BITS + 9;

    state_t state_reg, state_next;
    logic [CB-1:0] scan_reg, scan_next;
    logic [WB-1:0] wa_reg, wa_next, wb_reg, wb_next;
    logic [IB-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic          fa_reg, fa_next, fb_reg, fb_next;
    logic          ovf_reg, ovf_next;
    logic [8:0]    act_reg, act_next;
    logic          ov_valid_reg, ov_valid_next;
    logic [63:0]   od_reg, od_next;
    logic [8:0]    nz_reg;

    logic [COUNT_BITS-1:0] counts_reg [NUM_SYMBOLS];
    cell_cmd_t cmd;
    logic [WB-1:0] w [NUM_SYMBOLS];
    logic [MAX_CODE_BITS-1:0] cbits [NUM_SYMBOLS];
    logic [6:0]  clen [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] ovf_v;
    logic [WB-1:0] wscan;
    logic [IB-1:0] sidx;
    logic [63:0] rd_bits;
    logic [6:0]  rd_len;
    logic        old_nz, new_nz;

    logic [1:0]  op;
    logic [7:0]  sym;
    logic [23:0] cnt;
    assign op  = in_ch.data[33:32];
    assign sym = in_ch.data[31:24];
    assign cnt = in_ch.data[23:0];
    assign in_ch.ready = (state_reg == ST_IDLE) && !ov_valid_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_SYMBOLS; g++)
        begin : g_cell
            hcb_cell #(.IDX_BITS(IB), .W_BITS(WB), .C_BITS(COUNT_BITS),
                       .CODE_BITS(MAX_CODE_BITS), .LEN_BITS(7)) u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd), .my_idx(IB'(g)),
                .count(counts_reg[g]), .slot_a(sa_reg), .slot_b(sb_reg),
                .weight_a(wa_reg), .weight(w[g]), .code_bits(cbits[g]),
                .code_length(clen[g]), .ovf(ovf_v[g]));
        end
    endgenerate

    assign old_nz  = (counts_reg[sym[IB-1:0]] != '0);
    assign new_nz  = (COUNT_BITS'(cnt) != '0);
    assign rd_bits = 64'(cbits[sym[IB-1:0]]);
    assign rd_len  = clen[sym[IB-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SYMBOLS; i++)
                counts_reg[i] <= '0;
            nz_reg <= '0;
        end
        else if (in_ch.valid && in_ch.ready && op == OP_WRITE
                 && 32'(sym) < NUM_SYMBOLS)
        begin
            counts_reg[sym[IB-1:0]] <= COUNT_BITS'(cnt);
            if (new_nz && !old_nz)
                nz_reg <= nz_reg + 1'b1;
            else if (!new_nz && old_nz)
                nz_reg <= nz_reg - 1'b1;
        end
    end

    assign sidx  = scan_reg[IB-1:0];
    assign wscan = w[sidx];

    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        wa_next = wa_reg; wb_next = wb_reg;
        sa_next = sa_reg; sb_next = sb_reg;
        fa_next = fa_reg; fb_next = fb_reg;
        ovf_next = ovf_reg; act_next = act_reg;
        ov_valid_next = ov_valid_reg;
        od_next = od_reg;
        cmd = '0;
        if (ov_valid_reg && out_ch.ready)
            ov_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (op == OP_BUILD)
                    begin
                        cmd.clear = 1'b1;
                        state_next = ST_LOAD;
                        act_next = '0;
                        ovf_next = 1'b0;
                    end
                    else if (op == OP_READ)
                    begin
                        od_next = '0;
                        if (32'(sym) < NUM_SYMBOLS)
                            od_next = {rd_len[5:0], rd_bits[47:0], 10'd0};
                        ov_valid_next = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                act_next = nz_reg;
                scan_next = '0; fa_next = 1'b0; fb_next = 1'b0;
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (wscan != '0)
                begin
                    if (!fa_reg || wscan < wa_reg)
                    begin
                        wb_next = wa_reg; sb_next = sa_reg; fb_next = fa_reg;
                        wa_next = wscan; sa_next = sidx; fa_next = 1'b1;
                    end
                    else if (!fb_reg || wscan < wb_reg)
                    begin
                        wb_next = wscan; sb_next = sidx; fb_next = 1'b1;
                    end
                end
                scan_next = scan_reg + 1'b1;
                if (32'(scan_reg) == NUM_SYMBOLS - 1)
                    state_next = (fa_next && fb_next) ? ST_MERGE : ST_DONE;
            end
            ST_MERGE:
            begin
                cmd.merge = 1'b1;
                if (ovf_v != '0)
                    ovf_next = 1'b1;
                scan_next = '0; fa_next = 1'b0; fb_next = 1'b0;
                state_next = ST_FIND;
            end
            ST_DONE:
            begin
                od_next = {54'd0, act_reg, ovf_reg};
                ov_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_valid_reg <= 1'b0;
            act_reg <= '0;
            ovf_reg <= 1'b0;
            scan_reg <= '0;
            fa_reg <= 1'b0;
            fb_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_valid_reg <= ov_valid_next;
            act_reg <= act_next;
            ovf_reg <= ovf_next;
            scan_reg <= scan_next;
            fa_reg <= fa_next;
            fb_reg <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg <= wa_next; wb_reg <= wb_next;
        sa_reg <= sa_next; sb_reg <= sb_next;
        od_reg <= od_next;
    end

    assign out_ch.valid = ov_valid_reg;
    assign out_ch.data  = od_reg;
endmodule

@@ bench/hcb_checker.sv @@
`timescale 1ns / 1ps
module hcb_checker (
    input  logic clk,
    input  logic rst_n,
    hcb_if       in_ch,
    hcb_if       out_ch,
    output int   errors,
    output int   outstanding
);
    import hcb_pkg::*;

    localparam int NSYM    = 256;
    localparam int MAXBITS = 48;

    typedef struct packed {
        logic [5:0]  code_length;
        logic [47:0] code_bits;
        logic [8:0]  active_symbols;
        logic        length_overflow;
    } code_result_t;

    logic [23:0] sym_count [NSYM];
    logic [63:0] grp_weight [NSYM];
    logic [7:0]  sym_slot [NSYM];
    logic [63:0] sym_code [NSYM];
    int          sym_len [NSYM];
    int          n_active;
    logic        overflow;

    code_result_t awaited_codes[$];

    function automatic int lightest_group(int groups, int skip);
        int best;
        best = -1;
        for (int i = 0; i < groups; i++)
        begin
            if (i != skip && grp_weight[i] != 0)
            begin
                if (best < 0 || grp_weight[i] < grp_weight[best])
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic void prepend_bit(int slot, logic bitval);
        for (int s = 0; s < NSYM; s++)
        begin
            if (sym_count[s] != 0 && sym_slot[s] == slot)
            begin
                if (sym_len[s] >= MAXBITS)
                    overflow = 1'b1;
                else
                begin
                    sym_code[s][sym_len[s]] = bitval;
                    sym_len[s]++;
                end
            end
        end
    endfunction

    function automatic void build_codes();
        int groups;
        int a;
        int b;
        groups = 0;
        overflow = 1'b0;
        for (int s = 0; s < NSYM; s++)
        begin
            grp_weight[s] = '0;
            sym_code[s] = '0;
            sym_len[s] = 0;
        end
        for (int s = 0; s < NSYM; s++)
        begin
            if (sym_count[s] != 0)
            begin
                sym_slot[s] = groups[7:0];
                grp_weight[groups] = 64'(sym_count[s]);
                groups++;
            end
        end
        n_active = groups;
        for (int k = 0; k + 1 < groups; k++)
        begin
            a = lightest_group(groups, -1);
            b = (a < 0) ? -1 : lightest_group(groups, a);
            if (a < 0 || b < 0)
                break;
            prepend_bit(a, 1'b0);
            prepend_bit(b, 1'b1);
            for (int s = 0; s < NSYM; s++)
            begin
                if (sym_count[s] != 0 && sym_slot[s] == a)
                    sym_slot[s] = b[7:0];
            end
            grp_weight[b] += grp_weight[a];
            grp_weight[a] = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        code_result_t res;
        code_result_t exp_res;
        opcode_t      op;
        int           sym;
        if (!rst_n)
        begin
            for (int s = 0; s < NSYM; s++)
            begin
                sym_count[s] = '0;
                grp_weight[s] = '0;
                sym_slot[s] = '0;
                sym_code[s] = '0;
                sym_len[s] = 0;
            end
            n_active = 0;
            overflow = 1'b0;
            awaited_codes.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                op  = opcode_t'(in_ch.data[33:32]);
                sym = int'(in_ch.data[31:24]);
                case (op)
                    OP_WRITE: sym_count[sym] = in_ch.data[23:0];
                    OP_BUILD:
                    begin
                        build_codes();
                        res = '0;
                        res.active_symbols = n_active[8:0];
                        res.length_overflow = overflow;
                        awaited_codes.push_back(res);
                    end
                    OP_READ:
                    begin
                        res = '0;
                        res.code_length = sym_len[sym][5:0];
                        res.code_bits = sym_code[sym][47:0];
                        awaited_codes.push_back(res);
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                res = out_ch.data;
                if (awaited_codes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, res);
                end
                else
                begin
                    exp_res = awaited_codes.pop_front();
                    if (res.code_length !== exp_res.code_length)
                    begin
                        errors++;
                        $display("%0t: code_length expected %0d actual %0d",
                                 $time, exp_res.code_length, res.code_length);
                    end
                    if (res.code_bits !== exp_res.code_bits)
                    begin
                        errors++;
                        $display("%0t: code_bits expected %h actual %h",
                                 $time, exp_res.code_bits, res.code_bits);
                    end
                    if (res.active_symbols !== exp_res.active_symbols)
                    begin
                        errors++;
                        $display("%0t: active_symbols expected %0d actual %0d",
                                 $time, exp_res.active_symbols, res.active_symbols);
                    end
                    if (res.length_overflow !== exp_res.length_overflow)
                    begin
                        errors++;
                        $display("%0t: length_overflow expected %0b actual %0b",
                                 $time, exp_res.length_overflow, res.length_overflow);
                    end
                end
            end
            outstanding = awaited_codes.size();
        end
    end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import hcb_pkg::*;

    localparam int STALL_LIMIT = 300000;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   idle_pct;
    int   stall_pct;
    int   hold_cycles;
    int   quiet_cycles;
    int   n_builds;
    int   n_reads;
    int   n_writes;
    byte unsigned used_syms[$];

    hcb_if #(.W(34)) in_ch ();
    hcb_if #(.W(64)) out_ch ();

    huffman_code_builder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hcb_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(opcode_t op, logic [7:0] sym, logic [23:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = {op, sym, cnt};
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        case (op)
            OP_WRITE: n_writes++;
            OP_BUILD: n_builds++;
            OP_READ:  n_reads++;
            default: ;
        endcase
    endtask

    task automatic set_count(logic [7:0] sym, logic [23:0] cnt);
        send_request(OP_WRITE, sym, cnt);
        if (cnt != 0)
            used_syms.push_back(sym);
    endtask

    task automatic clear_counts();
        while (used_syms.size() > 0)
            send_request(OP_WRITE, used_syms.pop_front(), 24'd0);
    endtask

    task automatic build_and_read(int n_rand_reads);
        send_request(OP_BUILD, 8'($urandom), 24'($urandom));
        foreach (used_syms[i])
            send_request(OP_READ, used_syms[i], 24'($urandom));
        repeat (n_rand_reads)
            send_request(OP_READ, 8'($urandom), 24'($urandom));
    endtask

    task automatic random_sequence(int max_syms);
        int nsym;
        int kind;
        logic [23:0] cnt;
        clear_counts();
        nsym = $urandom_range(max_syms);
        kind = $urandom_range(3);
        for (int i = 0; i < nsym; i++)
        begin
            case (kind)
                0: cnt = 24'($urandom);
                1: cnt = 24'($urandom_range(4));
                2: cnt = 24'd1 << $urandom_range(23);
                default: cnt = 24'($urandom_range(50));
            endcase
            if ($urandom_range(9) == 0)
                send_request(OP_NONE, 8'($urandom), 24'($urandom));
            set_count(8'($urandom), cnt);
        end
        build_and_read($urandom_range(3));
    endtask

    initial
    begin
        logic [23:0] fa;
        logic [23:0] fb;
        logic [23:0] ft;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        idle_pct = 31;
        stall_pct = 69;
        n_builds = 0;
        n_reads = 0;
        n_writes = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, then a lone symbol, then extreme counts and a tie.
        build_and_read(2);
        set_count(8'd255, 24'hFFFFFF);
        build_and_read(1);
        set_count(8'd0, 24'hFFFFFF);
        set_count(8'd128, 24'd1);
        set_count(8'd127, 24'd1);
        send_request(OP_NONE, 8'hFF, 24'hFFFFFF);
        build_and_read(0);

        // Fibonacci counts over 34 symbols give a fully skewed tree.
        clear_counts();
        fa = 24'd1;
        fb = 24'd1;
        for (int i = 0; i < 34; i++)
        begin
            set_count(8'(i * 7), fa);
            ft = fa + fb;
            fa = fb;
            fb = ft;
        end
        build_and_read(0);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct  = (ph == 0) ? 31 : (ph == 1) ? 69 : 0;
            stall_pct = (ph == 0) ? 69 : (ph == 1) ? 31 : 0;
            if (ph == 2)
                hold_cycles = 400;
            for (int q = 0; q < 8; q++)
                random_sequence(12);
        end

        // One build over every symbol.
        clear_counts();
        for (int s = 0; s < 256; s++)
            set_count(8'(s), 24'($urandom_range(1000, 1)));
        send_request(OP_BUILD, 8'($urandom), 24'($urandom));
        repeat (32)
            send_request(OP_READ, 8'($urandom), 24'($urandom));

        in_ch.valid = 1'b0;
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        $display("Requests: %0d writes, %0d builds, %0d reads, with sender and receiver stalls.",
                 n_writes, n_builds, n_reads);
        $display("Covered empty, lone, tied, Fibonacci and full symbol sets.");
        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
